// ----- sv/cmsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsa_pkg
// shared constants and opcodes for the can mailbox slot allocator
// ----------------------------------------------------------------------------
package cmsa_pkg;

    localparam int SLOTS_DEFAULT = 32;

    localparam int OP_W   = 2;
    localparam int ID_W   = 29;
    localparam int SLOT_W = 5;
    localparam int MASK_W = 32;
    localparam int RC_W   = 6;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_RFIRST  = 2'd3;

endpackage

// ----- sv/cmsa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmsa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cmsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/can_mailbox_slot_allocator.sv -----
`timescale 1ns / 1ps
// release completes from the idle state; cancel and release-first scan one slot a cycle;
// allocate issues one owner read from the ram port per cycle.
// throughput: one operation at a time, busy high until the result strobe; the next start
// may come in the strobe cycle. results are not stalled by the receiver.
// reset: asynchronous, active low; every slot free, reserved count zero.
// ----------------------------------------------------------------------------
// can_mailbox_slot_allocator
// transmit slot table with allocate, release, cancel and release-first scans
// ----------------------------------------------------------------------------
module can_mailbox_slot_allocator #(
    parameter int SLOTS = cmsa_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cmsa_pkg::OP_W-1:0]     opcode,
    input  logic [cmsa_pkg::ID_W-1:0]     msg_id,
    input  logic [cmsa_pkg::SLOT_W-1:0]   slot_number,
    input  logic [cmsa_pkg::MASK_W-1:0]   slot_mask,
    input  logic                          cfg_wr_en,
    input  logic [cmsa_pkg::RC_W-1:0]     cfg_wr_data,
    output logic                          done,
    output logic                          ok,
    output logic [cmsa_pkg::SLOT_W-1:0]   slot_found,
    output logic [cmsa_pkg::MASK_W-1:0]   cleared_mask
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
    localparam logic [cmsa_pkg::RC_W-1:0] SLOTS_RC = cmsa_pkg::RC_W'(SLOTS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                        state_reg, state_next;
    logic [cmsa_pkg::OP_W-1:0]   op_reg, op_next;
    logic [cmsa_pkg::ID_W-1:0]   id_reg, id_next;
    logic [SLOTS-1:0]            mask_reg, mask_next;
    logic [SLOTS-1:0]            valid_reg, valid_next;
    logic [cmsa_pkg::RC_W-1:0]   rc_reg, rc_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        issue_on_reg, issue_on_next;
    logic                        cmp_on_reg, cmp_on_next;
    logic                        done_reg, done_next;
    logic                        ok_reg, ok_next;
    logic [IDX_W-1:0]            found_reg, found_next;
    logic [SLOTS-1:0]            cleared_reg, cleared_next;

    logic                        ram_we;
    logic                        ram_re;
    logic [cmsa_pkg::ID_W-1:0]   ram_rdata;
    logic                        rc_full;

    cmsa_ram #(
        .WIDTH (cmsa_pkg::ID_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmp_idx_reg),
        .wdata (id_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rc_full = (rc_reg >= SLOTS_RC);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        mask_next     = mask_reg;
        valid_next    = valid_reg;
        rc_next       = rc_reg;
        idx_next      = idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        issue_on_next = issue_on_reg;
        cmp_on_next   = cmp_on_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        found_next    = found_reg;
        cleared_next  = cleared_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (cfg_wr_en)
        begin
            rc_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = opcode;
                    id_next      = msg_id;
                    mask_next    = slot_mask[SLOTS-1:0];
                    ok_next      = 1'b0;
                    found_next   = '0;
                    cleared_next = '0;
                    case (opcode)
                        cmsa_pkg::OP_ALLOC:
                        begin
                            if (rc_full)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next    = ST_SCAN;
                                idx_next      = rc_reg[IDX_W-1:0];
                                issue_on_next = 1'b1;
                                cmp_on_next   = 1'b0;
                            end
                        end
                        cmsa_pkg::OP_RELEASE:
                        begin
                            done_next = 1'b1;
                            if (cmsa_pkg::RC_W'(slot_number) < SLOTS_RC)
                            begin
                                cleared_next[slot_number[IDX_W-1:0]] =
                                    valid_reg[slot_number[IDX_W-1:0]];
                                valid_next[slot_number[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        cmsa_pkg::OP_CANCEL:
                        begin
                            if (rc_full)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                idx_next   = rc_reg[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                            idx_next   = '0;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                case (op_reg)
                    cmsa_pkg::OP_ALLOC:
                    begin
                        // read of slot n overlaps the compare of slot n - 1
                        ram_re       = issue_on_reg;
                        cmp_on_next  = issue_on_reg;
                        cmp_idx_next = idx_reg;
                        if (issue_on_reg)
                        begin
                            if (idx_reg == LAST)
                            begin
                                issue_on_next = 1'b0;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        if (cmp_on_reg)
                        begin
                            if (!valid_reg[cmp_idx_reg] || ram_rdata == id_reg)
                            begin
                                ram_we                  = (id_reg != '0);
                                valid_next[cmp_idx_reg] = (id_reg != '0);
                                ok_next                 = 1'b1;
                                found_next              = cmp_idx_reg;
                                done_next               = 1'b1;
                                state_next              = ST_IDLE;
                            end
                            else if (cmp_idx_reg == LAST)
                            begin
                                done_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    cmsa_pkg::OP_CANCEL:
                    begin
                        if (mask_reg[idx_reg] && valid_reg[idx_reg])
                        begin
                            valid_next[idx_reg]   = 1'b0;
                            cleared_next[idx_reg] = 1'b1;
                        end
                        if (idx_reg == LAST)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (mask_reg[idx_reg])
                        begin
                            cleared_next[idx_reg] = valid_reg[idx_reg];
                            valid_next[idx_reg]   = 1'b0;
                            ok_next               = 1'b1;
                            found_next            = idx_reg;
                            done_next             = 1'b1;
                            state_next            = ST_IDLE;
                        end
                        else if (idx_reg == LAST)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= cmsa_pkg::OP_ALLOC;
            id_reg       <= '0;
            mask_reg     <= '0;
            valid_reg    <= '0;
            rc_reg       <= '0;
            idx_reg      <= '0;
            cmp_idx_reg  <= '0;
            issue_on_reg <= 1'b0;
            cmp_on_reg   <= 1'b0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            found_reg    <= '0;
            cleared_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            id_reg       <= id_next;
            mask_reg     <= mask_next;
            valid_reg    <= valid_next;
            rc_reg       <= rc_next;
            idx_reg      <= idx_next;
            cmp_idx_reg  <= cmp_idx_next;
            issue_on_reg <= issue_on_next;
            cmp_on_reg   <= cmp_on_next;
            done_reg     <= done_next;
            ok_reg       <= ok_next;
            found_reg    <= found_next;
            cleared_reg  <= cleared_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign ok           = ok_reg;
    assign slot_found   = cmsa_pkg::SLOT_W'(found_reg);
    assign cleared_mask = cmsa_pkg::MASK_W'(cleared_reg);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the transmit slot allocator against a cycle-free model of the slot
// table: directed corner cases, then phases of random operations under several
// reserved counts, with bursty start traffic and drain points between phases
// ----------------------------------------------------------------------------
import cmsa_pkg::*;

typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] found;
    logic [MASK_W-1:0] cleared;
} slot_outcome_t;

class slot_table_board;
    logic [ID_W-1:0] owner [SLOTS_DEFAULT];
    int unsigned     reserved;
    slot_outcome_t   outcome_q[$];
    int              errors;
    int              checked;
    int              alloc_misses;
    int              op_count [4];

    function new();
        foreach (owner[i]) owner[i] = '0;
        reserved = 0;
        errors = 0;
        checked = 0;
        alloc_misses = 0;
        foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void set_reserved(logic [RC_W-1:0] value);
        reserved = 32'(value);
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t ns: %s wrong, want %0h got %0h", $realtime, what, want, got);
    endtask

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [SLOT_W-1:0] slot, logic [MASK_W-1:0] mask);
        slot_outcome_t r;
        r = '0;
        op_count[op]++;
        case (op)
            OP_ALLOC:
            begin
                for (int i = reserved; i < SLOTS_DEFAULT; i++)
                begin
                    if (owner[i] == '0 || owner[i] == id)
                    begin
                        owner[i] = id;
                        r.ok = 1'b1;
                        r.found = i[SLOT_W-1:0];
                        break;
                    end
                end
                if (!r.ok)
                    alloc_misses++;
            end
            OP_RELEASE:
            begin
                if (owner[slot] != '0)
                    r.cleared[slot] = 1'b1;
                owner[slot] = '0;
            end
            OP_CANCEL:
            begin
                for (int i = reserved; i < SLOTS_DEFAULT; i++)
                begin
                    if (mask[i] && owner[i] != '0)
                    begin
                        owner[i] = '0;
                        r.cleared[i] = 1'b1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS_DEFAULT; i++)
                begin
                    if (mask[i])
                    begin
                        if (owner[i] != '0)
                            r.cleared[i] = 1'b1;
                        owner[i] = '0;
                        r.ok = 1'b1;
                        r.found = i[SLOT_W-1:0];
                        break;
                    end
                end
            end
        endcase
        outcome_q.push_back(r);
    endfunction

    task check_result(logic got_ok, logic [SLOT_W-1:0] got_found,
                      logic [MASK_W-1:0] got_cleared);
        slot_outcome_t e;
        if (outcome_q.size() == 0)
        begin
            report("result with no transfer outstanding", 32'd0, 32'd0);
            return;
        end
        e = outcome_q.pop_front();
        checked++;
        if (got_ok !== e.ok)
            report("ok", 32'(e.ok), 32'(got_ok));
        if (got_found !== e.found)
            report("slot_found", 32'(e.found), 32'(got_found));
        if (got_cleared !== e.cleared)
            report("cleared_mask", e.cleared, got_cleared);
    endtask
endclass

module testbench;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   opcode      = OP_ALLOC;
    logic [ID_W-1:0]   msg_id      = '0;
    logic [SLOT_W-1:0] slot_number = '0;
    logic [MASK_W-1:0] slot_mask   = '0;
    logic              cfg_wr_en   = 1'b0;
    logic [RC_W-1:0]   cfg_wr_data = '0;
    logic              done;
    logic              ok;
    logic [SLOT_W-1:0] slot_found;
    logic [MASK_W-1:0] cleared_mask;

    slot_table_board   sb = new();
    logic [ID_W-1:0]   id_pool [8];
    int                burst_left;
    int                rc_writes;

    can_mailbox_slot_allocator #(
        .SLOTS (SLOTS_DEFAULT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .msg_id       (msg_id),
        .slot_number  (slot_number),
        .slot_mask    (slot_mask),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .ok           (ok),
        .slot_found   (slot_found),
        .cleared_mask (cleared_mask)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(ok, slot_found, cleared_mask);
            if (start && !busy)
                sb.note_request(opcode, msg_id, slot_number, slot_mask);
            if (cfg_wr_en)
                sb.set_reserved(cfg_wr_data);
        end
    end

    task automatic send_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [SLOT_W-1:0] slot, logic [MASK_W-1:0] mask);
        start       <= 1'b1;
        opcode      <= op;
        msg_id      <= id;
        slot_number <= slot;
        slot_mask   <= mask;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // wait for every outstanding transfer to return, then let the scan settle
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reserved(logic [RC_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        rc_writes++;
    endtask

    task automatic random_op();
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [MASK_W-1:0] mask;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_ALLOC;
        else if (pick < 65)
            op = OP_RELEASE;
        else if (pick < 78)
            op = OP_CANCEL;
        else
            op = OP_RFIRST;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            id = '0;
        else if (pick < 55)
            id = id_pool[$urandom_range(0, 7)];
        else
            id = ID_W'($urandom());
        pick = $urandom_range(0, 9);
        if (pick == 0)
            mask = '0;
        else if (pick == 1)
            mask = '1;
        else if (pick < 5)
            mask = 32'h1 << $urandom_range(0, 31);
        else if (pick < 7)
            mask = $urandom() & $urandom();
        else
            mask = $urandom();
        send_op(op, id, SLOT_W'($urandom_range(0, 31)), mask);
    endtask

    initial
    begin
        int rc_list [10];
        rc_list = '{0, 31, 5, 32, 16, 63, 1, 28, 0, 0};
        rc_writes = 0;
        burst_left = 0;
        id_pool[0] = '1;
        id_pool[1] = 29'd1;
        id_pool[2] = 29'h0AAAAAAA;
        id_pool[3] = 29'h15555555;
        for (int i = 4; i < 8; i++)
            id_pool[i] = ID_W'($urandom());

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, first with no reserved slots, then with reserved counts 32 and 63
        send_op(OP_ALLOC,   '1,            0,  '0);
        send_op(OP_ALLOC,   '1,            0,  '0);
        send_op(OP_ALLOC,   '0,            0,  '0);
        send_op(OP_ALLOC,   29'd1,         0,  '0);
        send_op(OP_ALLOC,   29'h0AAAAAAA,  0,  '0);
        send_op(OP_ALLOC,   29'h15555555,  0,  '0);
        send_op(OP_RELEASE, '0,            31, '0);
        send_op(OP_RELEASE, '0,            0,  '0);
        send_op(OP_RELEASE, '0,            0,  '1);
        send_op(OP_RFIRST,  '1,            31, '0);
        send_op(OP_RFIRST,  '0,            0,  32'h8000_0000);
        send_op(OP_RFIRST,  '0,            0,  32'h0000_0006);
        send_op(OP_CANCEL,  '0,            0,  '1);
        send_op(OP_CANCEL,  '1,            31, '0);
        send_op(OP_ALLOC,   29'd7,         0,  '0);
        send_op(OP_ALLOC,   29'd9,         0,  '0);
        write_reserved(6'd32);
        send_op(OP_ALLOC,   29'd5,         0,  '0);
        send_op(OP_CANCEL,  '0,            0,  '1);
        send_op(OP_RELEASE, '0,            1,  '0);
        write_reserved(6'd63);
        send_op(OP_ALLOC,   '0,            0,  '0);
        send_op(OP_CANCEL,  '0,            0,  '1);
        send_op(OP_RFIRST,  '0,            0,  '1);

        for (int p = 0; p < 10; p++)
        begin
            if (p == 8)
                write_reserved(RC_W'($urandom_range(2, 30)));
            else
                write_reserved(RC_W'(rc_list[p]));
            for (int n = 0; n < 153; n++)
            begin
                random_op();
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 59) == 0)
                        drain();
                    else
                        idle($urandom_range(1, 12));
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(0, 12);
                end
                else
                    burst_left--;
            end
        end

        drain();
        repeat (40) @(posedge clk);
        $display("covered %0d transfers: %0d allocate (%0d with no slot), %0d release,",
                 sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
                 sb.op_count[0], sb.alloc_misses, sb.op_count[1]);
        $display("%0d cancel, %0d release-first, %0d results checked over %0d reserved counts",
                 sb.op_count[2], sb.op_count[3], sb.checked, rc_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timed out with %0d transfers outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
